// ----- sv/hrir_binaural_fir_downmix_macros.svh -----
// Assertion macros shared by the binaural downmix RTL.
`ifndef HRIR_BINAURAL_FIR_DOWNMIX_MACROS_SVH
`define HRIR_BINAURAL_FIR_DOWNMIX_MACROS_SVH

`ifndef NO_ASSERTIONS
`define HBFD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define HBFD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HBFD_ASSERT(lbl, clk, rstn, prop, msg)
`define HBFD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- sv/hbfd_pkg.sv -----
// Types and constants of the binaural downmix block.
package hbfd_pkg;

    localparam int SAMPLE_W = 24;
    localparam int COEF_W   = 24;
    localparam int NCH      = 8;
    localparam int MAP_W    = 3;
    localparam int TAPS_W   = 7;
    localparam int CHANS_W  = 4;
    localparam int PROD_W   = SAMPLE_W + COEF_W;
    localparam int SUM_W    = PROD_W + 3;
    localparam int ACC_W    = 64;
    localparam int SHIFT    = COEF_W - 2;
    localparam int CFG_W    = 24;

    typedef enum logic [1:0] {
        OP_FRAME = 2'd0,
        OP_COEF  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_CHANNELS  = 2'd0,
        CFG_TAPS      = 2'd1,
        CFG_LEFT_MAP  = 2'd2,
        CFG_RIGHT_MAP = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic        [1:0]          op;
        logic        [5:0]          tap_index;
        logic        [2:0]          hrir_channel;
        logic signed [COEF_W-1:0]   coef_value;
        logic signed [SAMPLE_W-1:0] sample_0;
        logic signed [SAMPLE_W-1:0] sample_1;
        logic signed [SAMPLE_W-1:0] sample_2;
        logic signed [SAMPLE_W-1:0] sample_3;
        logic signed [SAMPLE_W-1:0] sample_4;
        logic signed [SAMPLE_W-1:0] sample_5;
        logic signed [SAMPLE_W-1:0] sample_6;
        logic signed [SAMPLE_W-1:0] sample_7;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
        logic                       left_clipped;
        logic                       right_clipped;
    } t_out;

    typedef struct packed {
        logic [CHANS_W-1:0]   active_channels;
        logic [TAPS_W-1:0]    active_taps;
        logic [NCH*MAP_W-1:0] left_map;
        logic [NCH*MAP_W-1:0] right_map;
    } t_cfg;

endpackage

// ----- sv/hbfd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module hbfd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sv/hbfd_front.sv -----
// Front end: accepts words, drops unused ops and queues commands for the engine.
module hbfd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  hbfd_pkg::t_in i_data,
    output logic          o_cmd_valid,
    input  logic          i_cmd_ready,
    output hbfd_pkg::t_in o_cmd
);
    import hbfd_pkg::*;

    t_in        r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_count;
    logic       w_push;
    logic       w_pop;

    assign o_ready     = (r_count != 2'd2);
    assign w_push      = i_valid && o_ready && (t_op'(i_data.op) != OP_NONE);
    assign o_cmd_valid = (r_count != 2'd0);
    assign w_pop       = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_q[r_wp] <= i_data;
                r_wp      <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_count <= r_count + 2'(w_push) - 2'(w_pop);
        end
    end
endmodule

// ----- sv/hbfd_back.sv -----
// Engine: coefficient loads, history clears and the per-tap multiply-accumulate.
`include "hrir_binaural_fir_downmix_macros.svh"
module hbfd_back #(
    parameter int MAX_TAPS = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  hbfd_pkg::t_cfg i_cfg,
    input  logic           i_cmd_valid,
    output logic           o_cmd_ready,
    input  hbfd_pkg::t_in  i_cmd,
    output logic           o_valid,
    input  logic           i_ready,
    output hbfd_pkg::t_out o_data
);
    import hbfd_pkg::*;

    localparam int TAW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int TCW = $clog2(MAX_TAPS + 1);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN} t_state;

    t_state                     r_state;
    logic [TAW-1:0]             r_ring;
    logic [TAW-1:0]             r_tap;
    logic [TAW-1:0]             r_slot;
    logic [TAW-1:0]             r_last_idx;
    logic [CHANS_W-1:0]         r_chans;
    logic [MAX_TAPS-1:0]        r_row_valid;
    logic                       r_v1, r_l1, r_rv1;
    logic                       r_v2, r_l2;
    logic                       r_v3, r_l3;
    logic                       r_fin;
    logic signed [PROD_W-1:0]   r_pl [NCH];
    logic signed [PROD_W-1:0]   r_pr [NCH];
    logic signed [SUM_W-1:0]    r_sl;
    logic signed [SUM_W-1:0]    r_sr;
    logic signed [ACC_W-1:0]    r_accl;
    logic signed [ACC_W-1:0]    r_accr;
    logic                       r_out_valid;
    t_out                       r_out;

    logic                       w_pop;
    logic                       w_load;
    logic [TCW-1:0]             w_taps;
    logic [TAW-1:0]             w_ro;
    logic [TAW-1:0]             w_taps_m1;
    logic [NCH*SAMPLE_W-1:0]    w_hist_wdata;
    logic [NCH*SAMPLE_W-1:0]    w_hist_rdata;
    logic [COEF_W-1:0]          w_coef_rdata [NCH];
    logic [NCH-1:0]             w_coef_we;
    logic                       w_coef_ok;
    logic                       w_last;
    logic signed [PROD_W-1:0]   n_pl [NCH];
    logic signed [PROD_W-1:0]   n_pr [NCH];
    logic signed [SUM_W-1:0]    n_sl;
    logic signed [SUM_W-1:0]    n_sr;
    t_out                       n_out;

    assign o_cmd_ready = (r_state == S_IDLE);
    assign w_pop       = i_cmd_valid && o_cmd_ready;
    assign w_coef_ok   = (32'(i_cmd.tap_index) < MAX_TAPS);
    assign w_last      = (r_tap == r_last_idx);
    assign w_load      = (r_state == S_DRAIN) && r_fin && (!r_out_valid || i_ready);

    always_comb begin
        if (i_cfg.active_taps == '0) begin
            w_taps = TCW'(1);
        end else if (32'(i_cfg.active_taps) > MAX_TAPS) begin
            w_taps = TCW'(MAX_TAPS);
        end else begin
            w_taps = TCW'(i_cfg.active_taps);
        end
        w_taps_m1 = TAW'(w_taps - TCW'(1));
        w_ro = (TCW'(r_ring) >= w_taps) ? '0 : r_ring;
    end

    assign w_hist_wdata = {i_cmd.sample_7, i_cmd.sample_6, i_cmd.sample_5, i_cmd.sample_4,
                           i_cmd.sample_3, i_cmd.sample_2, i_cmd.sample_1, i_cmd.sample_0};

    hbfd_ram #(.WIDTH(NCH*SAMPLE_W), .DEPTH(MAX_TAPS)) u_hist (
        .i_clk   (i_clk),
        .i_we    (w_pop && (t_op'(i_cmd.op) == OP_FRAME)),
        .i_waddr (w_ro),
        .i_wdata (w_hist_wdata),
        .i_re    (r_state == S_RUN),
        .i_raddr (r_slot),
        .o_rdata (w_hist_rdata)
    );

    for (genvar g = 0; g < NCH; g++) begin : g_coef
        assign w_coef_we[g] = w_pop && (t_op'(i_cmd.op) == OP_COEF) && w_coef_ok
                              && (i_cmd.hrir_channel == MAP_W'(g));
        hbfd_ram #(.WIDTH(COEF_W), .DEPTH(MAX_TAPS)) u_coef (
            .i_clk   (i_clk),
            .i_we    (w_coef_we[g]),
            .i_waddr (TAW'(i_cmd.tap_index)),
            .i_wdata (i_cmd.coef_value),
            .i_re    (r_state == S_RUN),
            .i_raddr (r_tap),
            .o_rdata (w_coef_rdata[g])
        );
    end

    always_comb begin
        logic signed [SAMPLE_W-1:0] x;
        logic [MAP_W-1:0]           ml;
        logic [MAP_W-1:0]           mr;
        for (int k = 0; k < NCH; k++) begin
            x  = (r_rv1 && (CHANS_W'(k) < r_chans)) ? w_hist_rdata[k*SAMPLE_W +: SAMPLE_W] : '0;
            ml = i_cfg.left_map[k*MAP_W +: MAP_W];
            mr = i_cfg.right_map[k*MAP_W +: MAP_W];
            n_pl[k] = x * $signed(w_coef_rdata[ml]);
            n_pr[k] = x * $signed(w_coef_rdata[mr]);
        end
        n_sl = '0;
        n_sr = '0;
        for (int k = 0; k < NCH; k++) begin
            n_sl = n_sl + SUM_W'(r_pl[k]);
            n_sr = n_sr + SUM_W'(r_pr[k]);
        end
    end

    function automatic logic [SAMPLE_W:0] finish(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] t;
        logic signed [ACC_W-1:0] q;
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        t  = acc + (ACC_W'(1) <<< (SHIFT - 1));
        q  = t >>> SHIFT;
        hi = (ACC_W'(1) <<< (SAMPLE_W - 1)) - ACC_W'(1);
        lo = -hi - ACC_W'(1);
        if (q > hi) begin
            finish = {1'b1, hi[SAMPLE_W-1:0]};
        end else if (q < lo) begin
            finish = {1'b1, lo[SAMPLE_W-1:0]};
        end else begin
            finish = {1'b0, q[SAMPLE_W-1:0]};
        end
    endfunction

    always_comb begin
        logic [SAMPLE_W:0] fl;
        logic [SAMPLE_W:0] fr;
        fl = finish(r_accl);
        fr = finish(r_accr);
        n_out.left_out      = fl[SAMPLE_W-1:0];
        n_out.right_out     = fr[SAMPLE_W-1:0];
        n_out.left_clipped  = fl[SAMPLE_W];
        n_out.right_clipped = fr[SAMPLE_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ring      <= '0;
            r_row_valid <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_l1        <= 1'b0;
            r_l2        <= 1'b0;
            r_l3        <= 1'b0;
            r_fin       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1  <= (r_state == S_RUN);
            r_l1  <= (r_state == S_RUN) && w_last;
            r_rv1 <= r_row_valid[r_slot];
            r_v2  <= r_v1;
            r_l2  <= r_v1 && r_l1;
            r_v3  <= r_v2;
            r_l3  <= r_v2 && r_l2;
            r_pl  <= n_pl;
            r_pr  <= n_pr;
            r_sl  <= n_sl;
            r_sr  <= n_sr;
            if (r_v3) begin
                r_accl <= r_accl + ACC_W'(r_sl);
                r_accr <= r_accr + ACC_W'(r_sr);
                if (r_l3) begin
                    r_fin <= 1'b1;
                end
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_pop) begin
                        case (t_op'(i_cmd.op))
                            OP_CLEAR: begin
                                r_row_valid <= '0;
                                r_ring      <= '0;
                            end
                            OP_FRAME: begin
                                r_row_valid[w_ro] <= 1'b1;
                                r_slot     <= w_ro;
                                r_tap      <= '0;
                                r_last_idx <= w_taps_m1;
                                r_chans    <= (i_cfg.active_channels > CHANS_W'(NCH))
                                              ? CHANS_W'(NCH) : i_cfg.active_channels;
                                r_ring     <= (w_ro == '0) ? w_taps_m1 : w_ro - TAW'(1);
                                r_accl     <= '0;
                                r_accr     <= '0;
                                r_state    <= S_RUN;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_RUN: begin
                    r_tap  <= r_tap + TAW'(1);
                    r_slot <= (r_slot == r_last_idx) ? '0 : r_slot + TAW'(1);
                    if (w_last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (w_load) begin
                        r_out   <= n_out;
                        r_fin   <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `HBFD_ASSERT(a_pipe_busy, i_clk, i_rst_n, r_v3 |-> (r_state != S_IDLE), "pipeline active while idle")
    `HBFD_ASSERT(a_fin_drain, i_clk, i_rst_n, r_fin |-> (r_state == S_DRAIN), "sum done outside drain")
    `HBFD_ASSERT(a_slot_range, i_clk, i_rst_n, (r_state == S_RUN) |-> (r_slot <= r_last_idx), "slot beyond taps")
    `HBFD_ASSERT(a_out_src, i_clk, i_rst_n, $rose(r_out_valid) |-> ($past(r_state) == S_DRAIN), "result not from drain")
endmodule

// ----- sv/hrir_binaural_fir_downmix.sv -----
// Top level of the binaural FIR downmix block.
// A process-frame word first stores the frame, then runs one tap per cycle, reading one
// history row and one coefficient row for all eight channel lanes, and then passes through
// the multiply, add-tree, accumulate and rounding stages. Coefficient loads and history
// clears are done as the word is taken and leave the engine idle.
// Clearing is done with per-row valid bits and costs no sweep. A two-word queue in front
// of the engine takes new words while a frame is being computed, and the result register
// holds a finished pair until it is taken. Op 3 words are accepted and dropped.
module hrir_binaural_fir_downmix #(
    parameter int MAX_TAPS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  hbfd_pkg::t_in                i_in,
    output logic                         o_valid,
    input  logic                         i_ready,
    output hbfd_pkg::t_out               o_out,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_addr,
    input  logic [hbfd_pkg::CFG_W-1:0]   i_cfg_data
);
    import hbfd_pkg::*;

    t_cfg r_cfg;
    t_in  w_cmd;
    logic w_cmd_valid;
    logic w_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_channels <= CHANS_W'(2);
            r_cfg.active_taps     <= TAPS_W'(64);
            r_cfg.left_map        <= '0;
            r_cfg.right_map       <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_CHANNELS:  r_cfg.active_channels <= i_cfg_data[CHANS_W-1:0];
                CFG_TAPS:      r_cfg.active_taps     <= i_cfg_data[TAPS_W-1:0];
                CFG_LEFT_MAP:  r_cfg.left_map        <= i_cfg_data[NCH*MAP_W-1:0];
                CFG_RIGHT_MAP: r_cfg.right_map       <= i_cfg_data[NCH*MAP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    hbfd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_in),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready),
        .o_cmd       (w_cmd)
    );

    hbfd_back #(.MAX_TAPS(MAX_TAPS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_out)
    );
endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench of the binaural FIR downmix block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import hbfd_pkg::*;

    localparam int N_TAPS = 64;
    localparam int WATCHDOG = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_in         i_in;
    logic        o_valid;
    logic        i_ready;
    t_out        o_out;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_addr;
    logic [CFG_W-1:0] i_cfg_data;

    hrir_binaural_fir_downmix dut (.*);

    // Predictor state.
    logic [CHANS_W-1:0]   pr_chans;
    logic [TAPS_W-1:0]    pr_taps;
    logic [NCH*MAP_W-1:0] pr_lmap;
    logic [NCH*MAP_W-1:0] pr_rmap;
    logic signed [SAMPLE_W-1:0] hist [N_TAPS][NCH];
    logic signed [COEF_W-1:0]   coefs [N_TAPS][NCH];
    int unsigned ring_pos;

    t_out  pair_q[$];
    int    errors;
    int    n_results;
    int    n_words;
    int    idle_cycles;
    int    sink_hold;
    bit    sink_stall_en;
    bit    src_stall_en;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic signed [SAMPLE_W-1:0] round_sat(
        input logic signed [63:0] acc, output logic clip);
        logic signed [63:0] q;
        q = (acc + (64'sd1 <<< (SHIFT - 1))) >>> SHIFT;
        clip = 1'b0;
        if (q > 64'sd8388607) begin
            q = 64'sd8388607;
            clip = 1'b1;
        end else if (q < -64'sd8388608) begin
            q = -64'sd8388608;
            clip = 1'b1;
        end
        return q[SAMPLE_W-1:0];
    endfunction

    task automatic predict_word(input t_in w);
        int unsigned taps, chans, slot;
        logic signed [63:0] accl, accr;
        logic [2:0] ml, mr;
        logic signed [SAMPLE_W-1:0] lane [NCH];
        t_out r;
        case (t_op'(w.op))
            OP_COEF: coefs[w.tap_index][w.hrir_channel] = w.coef_value;
            OP_CLEAR: begin
                foreach (hist[a, b]) hist[a][b] = '0;
                ring_pos = 0;
            end
            OP_FRAME: begin
                taps = (pr_taps == 0) ? 1 : (pr_taps > N_TAPS ? N_TAPS : pr_taps);
                chans = (pr_chans > NCH) ? NCH : pr_chans;
                if (ring_pos >= taps) ring_pos = 0;
                lane = '{w.sample_0, w.sample_1, w.sample_2, w.sample_3,
                         w.sample_4, w.sample_5, w.sample_6, w.sample_7};
                for (int k = 0; k < NCH; k++) hist[ring_pos][k] = lane[k];
                accl = 0;
                accr = 0;
                for (int j = 0; j < taps; j++) begin
                    slot = (ring_pos + j) % taps;
                    for (int k = 0; k < chans; k++) begin
                        ml = pr_lmap[3*k +: 3];
                        mr = pr_rmap[3*k +: 3];
                        accl += 64'(hist[slot][k]) * 64'(coefs[j][ml]);
                        accr += 64'(hist[slot][k]) * 64'(coefs[j][mr]);
                    end
                end
                r.left_out = round_sat(accl, r.left_clipped);
                r.right_out = round_sat(accr, r.right_clipped);
                pair_q.push_back(r);
                ring_pos = (ring_pos == 0) ? taps - 1 : ring_pos - 1;
            end
            default: ;
        endcase
    endtask

    task automatic pause_random();
        if (src_stall_en && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
    endtask

    task automatic send_word(input t_in w);
        pause_random();
        i_in <= w;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_word(w);
        n_words++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pair_q.size() != 0) @(negedge i_clk);
        repeat (N_TAPS + 16) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_CHANNELS:  pr_chans = val[CHANS_W-1:0];
            CFG_TAPS:      pr_taps = val[TAPS_W-1:0];
            CFG_LEFT_MAP:  pr_lmap = val;
            CFG_RIGHT_MAP: pr_rmap = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic t_in rand_frame(input int mode);
        t_in w;
        w = '0;
        w.op = OP_FRAME;
        w.tap_index = 6'($urandom);
        w.hrir_channel = 3'($urandom);
        w.coef_value = 24'($urandom);
        {w.sample_0, w.sample_1, w.sample_2, w.sample_3} = {$urandom, $urandom, $urandom};
        {w.sample_4, w.sample_5, w.sample_6, w.sample_7} = {$urandom, $urandom, $urandom};
        if (mode == 1) begin
            w.sample_0 >>>= 6; w.sample_1 >>>= 6; w.sample_2 >>>= 6; w.sample_3 >>>= 6;
            w.sample_4 >>>= 6; w.sample_5 >>>= 6; w.sample_6 >>>= 6; w.sample_7 >>>= 6;
        end
        return w;
    endfunction

    function automatic t_in coef_word(input int tap, input int ch, input logic [23:0] v);
        t_in w;
        w = '0;
        w.op = OP_COEF;
        w.tap_index = 6'(tap);
        w.hrir_channel = 3'(ch);
        w.coef_value = v;
        return w;
    endfunction

    task automatic load_all_coefs(input int scale);
        logic signed [COEF_W-1:0] c;
        for (int t = 0; t < N_TAPS; t++)
            for (int c2 = 0; c2 < NCH; c2++) begin
                c = COEF_W'($urandom);
                if (scale > 0) c = c >>> scale;
                send_word(coef_word(t, c2, c));
            end
    endtask

    task automatic test_directed();
        t_in w;
        load_all_coefs(0);
        drain();
        write_reg(CFG_TAPS, 24'd1);
        write_reg(CFG_CHANNELS, 24'd8);
        write_reg(CFG_LEFT_MAP, 24'hFAC688);
        write_reg(CFG_RIGHT_MAP, 24'h05397F);
        send_word(coef_word(0, 0, 24'h400000));
        send_word(coef_word(0, 1, 24'h800000));
        w = '0;
        w.op = OP_FRAME;
        w.sample_0 = 24'h7FFFFF;
        send_word(w);
        w.sample_0 = 24'h800000;
        send_word(w);
        w = '0;
        w.op = OP_FRAME;
        w.sample_0 = 24'h7FFFFF; w.sample_1 = 24'h7FFFFF; w.sample_2 = 24'h7FFFFF;
        w.sample_3 = 24'h7FFFFF; w.sample_4 = 24'h7FFFFF; w.sample_5 = 24'h7FFFFF;
        w.sample_6 = 24'h7FFFFF; w.sample_7 = 24'h7FFFFF;
        send_word(w);
        w.sample_0 = 24'h800000; w.sample_1 = 24'h800000; w.sample_2 = 24'h800000;
        w.sample_3 = 24'h800000; w.sample_4 = 24'h800000; w.sample_5 = 24'h800000;
        w.sample_6 = 24'h800000; w.sample_7 = 24'h800000;
        send_word(w);
        w.op = OP_NONE;
        send_word(w);
        w.op = OP_CLEAR;
        send_word(w);
        send_word(rand_frame(0));
        drain();
        write_reg(CFG_CHANNELS, 24'd0);
        write_reg(CFG_TAPS, 24'd0);
        send_word(rand_frame(0));
        send_word(rand_frame(0));
        drain();
        write_reg(CFG_CHANNELS, 24'd15);
        write_reg(CFG_TAPS, 24'd127);
        send_word(rand_frame(0));
        send_word(rand_frame(0));
        drain();
        // A shorter ring after a longer one leaves the offset stale.
        write_reg(CFG_TAPS, 24'd3);
        send_word(rand_frame(0));
        send_word(rand_frame(0));
        drain();
    endtask

    task automatic test_random(input int n_items, input bit stalls);
        t_in w;
        int pick;
        src_stall_en = stalls;
        sink_stall_en = stalls;
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) w = rand_frame($urandom_range(0, 1));
            else if (pick < 92) w = coef_word($urandom, $urandom, 24'($urandom));
            else if (pick < 97) begin
                w = rand_frame(0);
                w.op = OP_CLEAR;
            end else begin
                w = rand_frame(0);
                w.op = OP_NONE;
            end
            send_word(w);
            if (i == n_items / 2) drain();
        end
        drain();
    endtask

    task automatic test_settings();
        int tap_set [6] = '{1, 2, 5, 16, 63, 64};
        for (int s = 0; s < 6; s++) begin
            write_reg(CFG_TAPS, CFG_W'(tap_set[s]));
            write_reg(CFG_CHANNELS, CFG_W'($urandom_range(1, 8)));
            write_reg(CFG_LEFT_MAP, CFG_W'($urandom));
            write_reg(CFG_RIGHT_MAP, CFG_W'($urandom));
            test_random(30, 1'b1);
        end
        write_reg(CFG_CHANNELS, 24'd8);
        write_reg(CFG_TAPS, 24'd8);
        test_random(40, 1'b0);
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            sink_hold = 0;
        end else if (sink_hold > 0) begin
            sink_hold--;
            i_ready <= 1'b0;
        end else if (sink_stall_en && $urandom_range(0, 7) == 0) begin
            sink_hold = $urandom_range(0, 15);
            i_ready <= 1'b0;
        end else i_ready <= 1'b1;
    end

    always @(posedge i_clk) begin
        t_out exp_pair;
        if (i_rst_n && o_valid && i_ready) begin
            n_results++;
            if (pair_q.size() == 0) begin
                $error("unexpected result %h", o_out);
                errors++;
            end else begin
                exp_pair = pair_q.pop_front();
                if (o_out.left_out !== exp_pair.left_out) begin
                    $error("left_out exp %h got %h", exp_pair.left_out, o_out.left_out);
                    errors++;
                end
                if (o_out.right_out !== exp_pair.right_out) begin
                    $error("right_out exp %h got %h", exp_pair.right_out, o_out.right_out);
                    errors++;
                end
                if (o_out.left_clipped !== exp_pair.left_clipped) begin
                    $error("left_clipped exp %b got %b", exp_pair.left_clipped,
                           o_out.left_clipped);
                    errors++;
                end
                if (o_out.right_clipped !== exp_pair.right_clipped) begin
                    $error("right_clipped exp %b got %b", exp_pair.right_clipped,
                           o_out.right_clipped);
                    errors++;
                end
            end
        end
        if ((i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_in = '0;
        i_cfg_we = 1'b0;
        i_cfg_addr = '0;
        i_cfg_data = '0;
        pr_chans = 4'd2;
        pr_taps = 7'd64;
        pr_lmap = '0;
        pr_rmap = '0;
        foreach (hist[a, b]) hist[a][b] = '0;
        foreach (coefs[a, b]) coefs[a][b] = '0;
        ring_pos = 0;
        errors = 0;
        n_results = 0;
        n_words = 0;
        idle_cycles = 0;
        sink_stall_en = 1'b0;
        src_stall_en = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_settings();
        $display("Sent %0d words with coefficient loads, clears and unused ops,", n_words);
        $display("checked %0d stereo results over tap counts 1 to 64 and all lanes.",
                 n_results);
        if (errors == 0 && pair_q.size() == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+sv
sv/hbfd_pkg.sv
sv/hbfd_ram.sv
sv/hbfd_front.sv
sv/hbfd_back.sv
sv/hrir_binaural_fir_downmix.sv
dv/tb_top.sv
